### src/stopwatch_with_lap_defines.svh
// assertion macros for the stopwatch with lap timer
// used by the top level; expects signals clock and reset in scope
`ifndef STOPWATCH_WITH_LAP_DEFINES_SVH
`define STOPWATCH_WITH_LAP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SWL_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("stopwatch check failed");

// next-cycle implication, disabled while in reset
`define SWL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("stopwatch check failed");

`endif

### src/swl_pkg.sv
// shared types, constants and time helpers for the stopwatch with lap timer
// no dependencies
`timescale 1ns / 1ps

package swl_pkg;

   localparam int TIME_BITS_DEFAULT = 32;
   localparam int FIFO_DEPTH = 4;

   localparam logic [9:0] DEBOUNCE_RESET = 10'd200;
   localparam logic [9:0] MS_LAST = 10'd999;
   localparam logic [5:0] SEC_LAST = 6'd59;
   localparam logic [5:0] MIN_LAST = 6'd59;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_STOP  = 2'd1,
      KIND_LAP   = 2'd2
   } swl_kind_type;

   typedef struct packed {
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic [9:0] millis;
   } swl_time_type;

   // one accepted tick that caused at least one result
   typedef struct packed {
      logic         has_ss;
      swl_kind_type ss_kind;
      swl_time_type ss_time;
      logic         has_lap;
      swl_time_type lap_span;
   } swl_event_type;

   localparam swl_time_type TIME_ZERO = '{minutes: 6'd0, seconds: 6'd0, millis: 10'd0};
   localparam swl_time_type TIME_ONE  = '{minutes: 6'd0, seconds: 6'd0, millis: 10'd1};

   // mixed-radix increment, hours dropped
   function automatic swl_time_type swl_time_inc(input swl_time_type t);
      swl_time_type r;
      r = t;
      if (t.millis == MS_LAST) begin
         r.millis = '0;
         if (t.seconds == SEC_LAST) begin
            r.seconds = '0;
            if (t.minutes == MIN_LAST) begin
               r.minutes = '0;
            end else begin
               r.minutes = t.minutes + 6'd1;
            end
         end else begin
            r.seconds = t.seconds + 6'd1;
         end
      end else begin
         r.millis = t.millis + 10'd1;
      end
      return r;
   endfunction

endpackage

### src/swl_front.sv
// front end: edge detect, debounce lockout, elapsed-time counters
// depends on swl_pkg
`timescale 1ns / 1ps

module swl_front #(
   parameter int TIME_BITS = swl_pkg::TIME_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    start_stop_level,
   input  logic                    lap_level,
   input  logic                    csr_write_en,
   input  logic [9:0]              csr_write_data,
   output logic                    push,
   output swl_pkg::swl_event_type  event_out,
   output logic                    running
);

   logic                   running_ff, running_in;
   logic                   prev_ss_ff;
   logic                   prev_lap_ff;
   logic [9:0]             lockout_ff, lockout_in;
   logic [9:0]             debounce_ff;
   logic [TIME_BITS-1:0]   start_cnt_ff, start_cnt_in;
   logic [TIME_BITS-1:0]   lap_cnt_ff, lap_cnt_in;
   swl_pkg::swl_time_type  start_time_ff, start_time_in;
   swl_pkg::swl_time_type  lap_span_ff, lap_span_in;
   logic                   ss_edge, lap_edge, taken;

   always_comb begin
      ss_edge  = start_stop_level && !prev_ss_ff;
      lap_edge = lap_level && !prev_lap_ff;

      // free-running elapsed counters, mixed radix clears when binary wraps
      start_cnt_in  = start_cnt_ff + {{(TIME_BITS-1){1'b0}}, 1'b1};
      start_time_in = (&start_cnt_ff) ? swl_pkg::TIME_ZERO
                                      : swl_pkg::swl_time_inc(start_time_ff);
      lap_cnt_in    = lap_cnt_ff + {{(TIME_BITS-1){1'b0}}, 1'b1};
      lap_span_in   = (&lap_cnt_ff) ? swl_pkg::TIME_ZERO
                                    : swl_pkg::swl_time_inc(lap_span_ff);

      running_in = running_ff;
      lockout_in = lockout_ff;
      taken      = 1'b0;
      event_out  = '{has_ss: 1'b0, ss_kind: swl_pkg::KIND_START,
                     ss_time: swl_pkg::TIME_ZERO, has_lap: 1'b0,
                     lap_span: swl_pkg::TIME_ZERO};

      if (lockout_ff != '0) begin
         lockout_in = lockout_ff - 10'd1;
      end else begin
         if (ss_edge) begin
            taken = 1'b1;
            event_out.has_ss = 1'b1;
            if (!running_ff) begin
               running_in    = 1'b1;
               event_out.ss_kind = swl_pkg::KIND_START;
               start_cnt_in  = {{(TIME_BITS-1){1'b0}}, 1'b1};
               start_time_in = swl_pkg::TIME_ONE;
               lap_cnt_in    = {{(TIME_BITS-1){1'b0}}, 1'b1};
               lap_span_in   = swl_pkg::TIME_ONE;
               // lap on the same tick reports zero time
               if (lap_edge) begin
                  event_out.has_lap  = 1'b1;
                  event_out.lap_span = swl_pkg::TIME_ZERO;
               end
            end else begin
               running_in        = 1'b0;
               event_out.ss_kind = swl_pkg::KIND_STOP;
               event_out.ss_time = start_time_ff;
            end
         end else if (lap_edge && running_ff) begin
            taken              = 1'b1;
            event_out.has_lap  = 1'b1;
            event_out.lap_span = lap_span_ff;
            lap_cnt_in         = {{(TIME_BITS-1){1'b0}}, 1'b1};
            lap_span_in        = swl_pkg::TIME_ONE;
         end
         if (taken) begin
            lockout_in = debounce_ff;
         end
      end
      push = accept && taken;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b0;
         prev_ss_ff  <= 1'b0;
         prev_lap_ff <= 1'b0;
         lockout_ff  <= '0;
      end else if (accept) begin
         running_ff  <= running_in;
         prev_ss_ff  <= start_stop_level;
         prev_lap_ff <= lap_level;
         lockout_ff  <= lockout_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= swl_pkg::DEBOUNCE_RESET;
      end else if (csr_write_en) begin
         debounce_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         start_cnt_ff  <= start_cnt_in;
         start_time_ff <= start_time_in;
         lap_cnt_ff    <= lap_cnt_in;
         lap_span_ff   <= lap_span_in;
      end
   end

   assign running = running_ff;

endmodule

### src/swl_fifo.sv
// small event queue between front and back
// depends on swl_pkg
`timescale 1ns / 1ps

module swl_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  swl_pkg::swl_event_type  push_data,
   input  logic                    pop,
   output swl_pkg::swl_event_type  head,
   output logic                    empty,
   output logic                    full
);

   localparam int PTR_BITS = $clog2(swl_pkg::FIFO_DEPTH);
   localparam int CNT_BITS = $clog2(swl_pkg::FIFO_DEPTH + 1);

   swl_pkg::swl_event_type  entry_ff [swl_pkg::FIFO_DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0]     count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_BITS'(swl_pkg::FIFO_DEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(swl_pkg::FIFO_DEPTH - 1))
                         ? '0 : wr_ptr_ff + PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(swl_pkg::FIFO_DEPTH - 1))
                         ? '0 : rd_ptr_ff + PTR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/swl_back.sv
// back end: splits queued events into result items, output register
// depends on swl_pkg
`timescale 1ns / 1ps

module swl_back (
   input  logic                    clock,
   input  logic                    reset,
   input  swl_pkg::swl_event_type  head,
   input  logic                    empty,
   output logic                    pop,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_kind,
   output logic [5:0]              rsp_minutes,
   output logic [5:0]              rsp_seconds,
   output logic [9:0]              rsp_millis,
   output logic                    rsp_led_on,
   output logic                    rsp_is_last
);

   logic                   valid_ff, valid_in;
   logic                   phase_ff, phase_in;
   swl_pkg::swl_kind_type  kind_ff, kind_in;
   swl_pkg::swl_time_type  time_ff, time_in;
   logic                   led_ff, led_in;
   logic                   last_ff, last_in;
   logic                   load;

   always_comb begin
      load     = !empty && (!valid_ff || rsp_ready);
      valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
      phase_in = phase_ff;
      pop      = 1'b0;
      if (head.has_ss && !phase_ff) begin
         kind_in = head.ss_kind;
         time_in = head.ss_time;
         led_in  = (head.ss_kind == swl_pkg::KIND_START);
         last_in = !head.has_lap;
         if (load) begin
            pop      = !head.has_lap;
            phase_in = head.has_lap;
         end
      end else begin
         kind_in = swl_pkg::KIND_LAP;
         time_in = head.lap_span;
         led_in  = 1'b1;
         last_in = 1'b1;
         if (load) begin
            pop      = 1'b1;
            phase_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind_in;
         time_ff <= time_in;
         led_ff  <= led_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_kind    = kind_ff;
   assign rsp_minutes = time_ff.minutes;
   assign rsp_seconds = time_ff.seconds;
   assign rsp_millis  = time_ff.millis;
   assign rsp_led_on  = led_ff;
   assign rsp_is_last = last_ff;

endmodule

### src/stopwatch_with_lap.sv
// stopwatch with lap timer, top level
// depends on swl_pkg, swl_front, swl_fifo, swl_back and stopwatch_with_lap_defines.svh
`timescale 1ns / 1ps
//
// usage
// - req channel: one transfer per millisecond tick, carrying the sampled
//   start/stop and lap button levels
// - rsp channel: one transfer per result; a tick gives zero, one or two
//   results, and is_last marks the final one of a tick
// - csr port: csr_write_en with csr_write_data loads the debounce length;
//   write only while the block is idle
// - path: a result is registered in the event queue and then in the output
//   register before it is presented on rsp
// - throughput: one tick per cycle while the event queue is not full; a tick
//   with two results holds the output register for both, the 4-entry event queue absorbs that
// - req_ready drops only when the event queue is full, which happens when
//   the receiver stalls rsp_ready long enough
// - elapsed times come from per-mark counters kept in minutes, seconds and
//   milliseconds alongside a binary wrap counter, so no divider is needed
// - reset: stopped, no lockout, queue empty, debounce length 200 ticks
//
`include "stopwatch_with_lap_defines.svh"

module stopwatch_with_lap #(
   parameter int TIME_BITS = swl_pkg::TIME_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_start_stop_level,
   input  logic        req_lap_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [5:0]  rsp_minutes,
   output logic [5:0]  rsp_seconds,
   output logic [9:0]  rsp_millis,
   output logic        rsp_led_on,
   output logic        rsp_is_last,
   input  logic        csr_write_en,
   input  logic [9:0]  csr_write_data
);

   // front to queue
   logic                    push;
   swl_pkg::swl_event_type  event_data;
   logic                    running;
   // queue to back
   swl_pkg::swl_event_type  head;
   logic                    empty, full, pop;
   logic                    accept;
   // short views used by the checks
   logic                    rsp_is_start, rsp_is_stop, rsp_time_zero, push_stop;

   // a tick may always push, so only a full queue holds off the sender
   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   swl_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .start_stop_level (req_start_stop_level),
      .lap_level        (req_lap_level),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .push             (push),
      .event_out        (event_data),
      .running          (running)
   );

   swl_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (event_data),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .full      (full)
   );

   swl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .empty       (empty),
      .pop         (pop),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_kind    (rsp_kind),
      .rsp_minutes (rsp_minutes),
      .rsp_seconds (rsp_seconds),
      .rsp_millis  (rsp_millis),
      .rsp_led_on  (rsp_led_on),
      .rsp_is_last (rsp_is_last)
   );

   assign rsp_is_start  = (rsp_kind == swl_pkg::KIND_START);
   assign rsp_is_stop   = (rsp_kind == swl_pkg::KIND_STOP);
   assign rsp_time_zero = (rsp_minutes == 6'd0) && (rsp_seconds == 6'd0)
                          && (rsp_millis == 10'd0);
   assign push_stop     = push && event_data.has_ss
                          && (event_data.ss_kind == swl_pkg::KIND_STOP);

   // a start result always reports zero time
   `SWL_ASSERT_IMPLY(a_start_zero, rsp_valid && rsp_is_start, rsp_time_zero)
   // a stop ends the tick's results, a lap never follows it
   `SWL_ASSERT_IMPLY(a_stop_last, rsp_valid && rsp_is_stop, rsp_is_last && !rsp_led_on)
   // a tick that stops the watch pushes no lap event
   `SWL_ASSERT_IMPLY(a_stop_no_lap, push_stop, !event_data.has_lap)
   // a stop event leaves the watch stopped on the next cycle
   `SWL_ASSERT_NEXT(a_stop_clears_run, push_stop, !running)

endmodule
